FILE: rtl/bmf_pkg.sv
// shared constants and types for the box mean filter
`timescale 1ns / 1ps
package bmf_pkg;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_WINDOW_DEF = 15;

    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_WINDOW_HEIGHT = 2'd2;
    localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_OUT
    } state_t;
endpackage

FILE: rtl/bmf_divider.sv
// restoring divider with round-half-even and saturation to 8 bits
`timescale 1ns / 1ps
module bmf_divider
    import bmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [7:0]  quotient
);
    logic [15:0] q_reg, q_next;
    logic [8:0]  r_reg, r_next;
    logic [7:0]  d_reg, d_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [9:0]  trial;
    logic [9:0]  twice_r;
    logic [16:0] q_round;

    assign trial = {r_reg, q_reg[15]} - {2'b0, d_reg};
    assign twice_r = {r_reg, 1'b0};
    always_comb
    begin
        q_round = {1'b0, q_reg};
        if (twice_r > {2'b0, d_reg} || (twice_r == {2'b0, d_reg} && q_reg[0]))
        begin
            q_round = {1'b0, q_reg} + 17'd1;
        end
    end

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[9])
            begin
                r_next = {r_reg[7:0], q_reg[15]};
                q_next = {q_reg[14:0], 1'b0};
            end
            else
            begin
                r_next = trial[8:0];
                q_next = {q_reg[14:0], 1'b1};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quotient = (q_round > 17'd255) ? 8'd255 : q_round[7:0];
endmodule

FILE: rtl/box_mean_filter.sv
// box mean filter top level: line store, column sums, window sum
`timescale 1ns / 1ps
// channel | dir | handshake           | payload
// pixel   | in  | pixel_valid/stall   | pixel_in
// mean    | out | mean_valid/stall    | mean_out, out_row, out_col, frame_last
// config  | in  | cfg_we              | cfg_index, cfg_data
// each pixel passes store read, column sum write and window update; one that
// makes a result then holds the input stalled through a 16-step serial divide
// for the rounded mean. results wait in an output register until taken;
// the next pixel is accepted while a result waits there, but a finished mean
// that still needs the occupied register holds the input stalled. reset
// clears counters and window sum; the stores need no clearing.
module box_mean_filter
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  logic [7:0]  pixel_in,
    output logic        mean_valid,
    input  logic        mean_stall,
    output logic [7:0]  mean_out,
    output logic [15:0] out_row,
    output logic [9:0]  out_col,
    output logic        frame_last
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_WINDOW);
    localparam int SD = MAX_WINDOW * MAX_WIDTH;
    localparam int SW = $clog2(SD);

    logic [10:0] img_w_reg;
    logic [15:0] img_h_reg;
    logic [3:0]  win_h_reg, win_w_reg;

    logic [15:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] slot_row_reg;
    logic [15:0] wsum_reg;
    logic [7:0]  px_reg;
    state_t      state_reg, state_next;

    logic [7:0]  row_store [SD];
    logic [11:0] col_sums [MAX_WIDTH];
    logic [7:0]  old_px;
    logic [11:0] cs_rd, cs_old_rd;
    logic [11:0] cs_new_reg;

    logic [15:0] eff_w, eff_h;
    logic        win_ok;
    logic [15:0] row_c;
    logic [15:0] col_c;
    logic [SW-1:0] slot;
    logic [11:0] cs_new;
    logic [CW-1:0] old_col;

    logic        emit_reg, last_reg;
    logic [15:0] orow_reg;
    logic [9:0]  ocol_reg;
    logic        div_start, div_done;
    logic [7:0]  quot;
    logic        waiting_reg;
    logic        held_reg;
    logic        load_out;
    logic        ov_reg;
    logic [7:0]  om_reg;
    logic [15:0] or_reg;
    logic [9:0]  oc_reg;
    logic        ol_reg;

    always_comb
    begin
        eff_w = {5'd0, img_w_reg};
        if (img_w_reg == 11'd0)
        begin
            eff_w = 16'd1;
        end
        else if ({5'd0, img_w_reg} > 16'(MAX_WIDTH))
        begin
            eff_w = 16'(MAX_WIDTH);
        end
        eff_h = (img_h_reg == 16'd0) ? 16'd1 : img_h_reg;
        win_ok = win_h_reg != 4'd0 && win_w_reg != 4'd0 &&
                 32'(win_h_reg) <= MAX_WINDOW && 32'(win_w_reg) <= MAX_WINDOW;
    end

    // counters are kept in range, clamp not needed beyond frame restart
    assign row_c = row_reg;
    assign col_c = {{(16-CW){1'b0}}, col_reg};
    assign slot = SW'(32'(slot_row_reg) * MAX_WIDTH + 32'(col_reg));
    assign old_col = col_reg - CW'(win_w_reg);

    always_comb
    begin
        if (row_c == 16'd0)
        begin
            cs_new = {4'd0, px_reg};
        end
        else if (row_c >= {12'd0, win_h_reg})
        begin
            cs_new = cs_rd - {4'd0, old_px} + {4'd0, px_reg};
        end
        else
        begin
            cs_new = cs_rd + {4'd0, px_reg};
        end
    end

    logic accept;
    logic out_take;
    assign accept = pixel_valid && !pixel_stall;
    assign out_take = ov_reg && !mean_stall;
    // a finished mean moves into the output register once it is free
    assign load_out = (div_done || held_reg) && (!ov_reg || !mean_stall);
    assign pixel_stall = (state_reg != ST_IDLE) || waiting_reg;
    // row store and column sums: registered reads, writes in ST_READ
    always_ff @(posedge clk)
    begin
        old_px <= row_store[slot];
        cs_rd <= col_sums[col_reg];
        cs_old_rd <= col_sums[old_col];
        if (state_reg == ST_READ && win_ok)
        begin
            row_store[slot] <= px_reg;
            col_sums[col_reg] <= cs_new;
        end
        if (state_reg == ST_READ)
        begin
            cs_new_reg <= cs_new;
        end
        if (accept)
        begin
            px_reg <= pixel_in;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_READ;
            ST_READ: state_next = ST_SUM;
            ST_SUM:  state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    logic [15:0] wsum_new;
    logic        hit;
    always_comb
    begin
        wsum_new = (col_reg == '0) ? 16'd0 : wsum_reg;
        wsum_new = wsum_new + {4'd0, cs_new_reg};
        if (col_c >= {12'd0, win_w_reg})
        begin
            wsum_new = wsum_new - {4'd0, cs_old_rd};
        end
        hit = win_ok && (row_c + 16'd1 >= {12'd0, win_h_reg}) &&
              (col_c + 16'd1 >= {12'd0, win_w_reg});
    end

    logic [7:0] area;
    assign area = {4'd0, win_h_reg} * {4'd0, win_w_reg};
    assign div_start = emit_reg;

    bmf_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(wsum_reg),
        .divisor(area), .done(div_done), .quotient(quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= 11'd1024;
            img_h_reg <= 16'd768;
            win_h_reg <= 4'd3;
            win_w_reg <= 4'd3;
            row_reg <= '0;
            col_reg <= '0;
            slot_row_reg <= '0;
            wsum_reg <= '0;
            state_reg <= ST_IDLE;
            emit_reg <= 1'b0;
            waiting_reg <= 1'b0;
            held_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            emit_reg <= 1'b0;
            if (state_reg == ST_SUM && win_ok)
            begin
                wsum_reg <= wsum_new;
            end
            if (state_reg == ST_OUT)
            begin
                if (hit)
                begin
                    emit_reg <= 1'b1;
                    waiting_reg <= 1'b1;
                end
                if (col_c + 16'd1 >= eff_w)
                begin
                    col_reg <= '0;
                    if (row_c + 16'd1 >= eff_h)
                    begin
                        row_reg <= '0;
                        slot_row_reg <= '0;
                    end
                    else
                    begin
                        row_reg <= row_reg + 16'd1;
                        slot_row_reg <= (slot_row_reg + RW'(1) >= RW'(win_h_reg)) ?
                                        '0 : slot_row_reg + RW'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (load_out)
            begin
                waiting_reg <= 1'b0;
                held_reg <= 1'b0;
                ov_reg <= 1'b1;
            end
            else
            begin
                if (div_done)
                begin
                    held_reg <= 1'b1;
                end
                if (out_take)
                begin
                    ov_reg <= 1'b0;
                end
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:   img_w_reg <= cfg_data[10:0];
                    REG_IMAGE_HEIGHT:  img_h_reg <= cfg_data;
                    REG_WINDOW_HEIGHT: win_h_reg <= cfg_data[3:0];
                    REG_WINDOW_WIDTH:  win_w_reg <= cfg_data[3:0];
                    default: ;
                endcase
                row_reg <= '0;
                col_reg <= '0;
                slot_row_reg <= '0;
                wsum_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && hit)
        begin
            orow_reg <= row_c - {12'd0, win_h_reg} + 16'd1 +
                        {13'd0, 3'((win_h_reg - 4'd1) >> 1)};
            ocol_reg <= 10'(col_c - {12'd0, win_w_reg} + 16'd1 +
                        {13'd0, 3'((win_w_reg - 4'd1) >> 1)});
            last_reg <= (row_c + 16'd1 == eff_h) && (col_c + 16'd1 == eff_w);
        end
        if (load_out)
        begin
            om_reg <= quot;
            or_reg <= orow_reg;
            oc_reg <= ocol_reg;
            ol_reg <= last_reg;
        end
    end

    assign mean_valid = ov_reg;
    assign mean_out = om_reg;
    assign out_row = or_reg;
    assign out_col = oc_reg;
    assign frame_last = ol_reg;
endmodule
